// ===== design/cdq_pkg.sv =====
package cdq_pkg;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_CHG  = 2'd1,
		DIR_DSG  = 2'd2
	} dir_t;

	typedef enum logic [2:0] {
		REG_SWITCH_FILTER = 3'd0,
		REG_IDLE_FILTER   = 3'd1,
		REG_CHARGE_THR    = 3'd2,
		REG_DISCHARGE_THR = 3'd3,
		REG_IDLE_MID      = 3'd4
	} reg_idx_t;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	typedef struct packed {
		logic        [7:0]  switch_filter;
		logic        [7:0]  idle_filter;
		logic signed [15:0] charge_threshold;
		logic signed [15:0] discharge_threshold;
		logic signed [15:0] idle_midpoint;
	} cfg_t;

	typedef struct packed {
		dir_t direction;
		logic changed;
	} res_t;

endpackage

// ===== design/cdq_regs.sv =====
module cdq_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cdq_pkg::ADDR_W-1:0]  paddr,
	input  logic [cdq_pkg::DATA_W-1:0]  pwdata,
	output logic [cdq_pkg::DATA_W-1:0]  prdata,
	output cdq_pkg::cfg_t               cfg
);
	import cdq_pkg::*;

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;

	assign wr_en = psel && penable && pwrite;
	assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.switch_filter       <= 8'd5;
			cfg_q.idle_filter         <= 8'd10;
			cfg_q.charge_threshold    <= 16'sd20;
			cfg_q.discharge_threshold <= -16'sd20;
			cfg_q.idle_midpoint       <= 16'sd0;
		end else if (wr_en) begin
			case (idx)
				REG_SWITCH_FILTER: cfg_q.switch_filter       <= pwdata[7:0];
				REG_IDLE_FILTER:   cfg_q.idle_filter         <= pwdata[7:0];
				REG_CHARGE_THR:    cfg_q.charge_threshold    <= signed'(pwdata[15:0]);
				REG_DISCHARGE_THR: cfg_q.discharge_threshold <= signed'(pwdata[15:0]);
				REG_IDLE_MID:      cfg_q.idle_midpoint       <= signed'(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SWITCH_FILTER: prdata = {24'd0, cfg_q.switch_filter};
			REG_IDLE_FILTER:   prdata = {24'd0, cfg_q.idle_filter};
			REG_CHARGE_THR:    prdata = DATA_W'(cfg_q.charge_threshold);
			REG_DISCHARGE_THR: prdata = DATA_W'(cfg_q.discharge_threshold);
			REG_IDLE_MID:      prdata = DATA_W'(cfg_q.idle_midpoint);
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== design/cdq_core.sv =====
module cdq_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic signed [15:0] cur,
	input  cdq_pkg::cfg_t      cfg,
	output cdq_pkg::res_t      res
);
	import cdq_pkg::*;

	dir_t       state_q, state_d;
	logic [7:0] idle_cnt_q, dsg_cnt_q, chg_cnt_q;
	logic [7:0] idle_cnt_d, dsg_cnt_d, chg_cnt_d;

	// next state: per-state counting, then priority select
	always_comb begin
		logic       ge_chg, le_dsg, ge_mid, le_mid;
		logic [7:0] idle_c, dsg_c, chg_c;
		ge_chg = cur >= cfg.charge_threshold;
		le_dsg = cur <= cfg.discharge_threshold;
		ge_mid = cur >= cfg.idle_midpoint;
		le_mid = cur <= cfg.idle_midpoint;
		idle_c = idle_cnt_q;
		dsg_c  = dsg_cnt_q;
		chg_c  = chg_cnt_q;
		case (state_q)
			DIR_DSG: begin
				if (ge_chg) begin
					chg_c  = chg_cnt_q + 8'd1;
					idle_c = idle_cnt_q + 8'd1;
				end else if (ge_mid) begin
					chg_c  = '0;
					idle_c = idle_cnt_q + 8'd1;
				end else begin
					chg_c  = '0;
					idle_c = '0;
				end
				dsg_c = '0;
			end
			DIR_CHG: begin
				if (le_dsg) begin
					idle_c = idle_cnt_q + 8'd1;
					dsg_c  = dsg_cnt_q + 8'd1;
				end else if (le_mid) begin
					idle_c = idle_cnt_q + 8'd1;
					dsg_c  = '0;
				end else begin
					idle_c = '0;
					dsg_c  = '0;
				end
				chg_c = '0;
			end
			default: begin
				if (le_dsg) begin
					dsg_c = dsg_cnt_q + 8'd1;
					chg_c = '0;
				end else if (ge_chg) begin
					chg_c = chg_cnt_q + 8'd1;
					dsg_c = '0;
				end else begin
					dsg_c = '0;
					chg_c = '0;
				end
				idle_c = '0;
			end
		endcase
		state_d    = state_q;
		idle_cnt_d = idle_c;
		dsg_cnt_d  = dsg_c;
		chg_cnt_d  = chg_c;
		if (dsg_c >= cfg.switch_filter) begin
			dsg_cnt_d = '0;
			state_d   = DIR_DSG;
		end else if (chg_c >= cfg.switch_filter) begin
			chg_cnt_d = '0;
			state_d   = DIR_CHG;
		end else if (idle_c >= cfg.idle_filter) begin
			idle_cnt_d = '0;
			state_d    = DIR_IDLE;
		end
	end

	always_comb begin
		res.direction = state_d;
		res.changed   = state_d != state_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= DIR_IDLE;
			idle_cnt_q <= '0;
			dsg_cnt_q  <= '0;
			chg_cnt_q  <= '0;
		end else if (en) begin
			state_q    <= state_d;
			idle_cnt_q <= idle_cnt_d;
			dsg_cnt_q  <= dsg_cnt_d;
			chg_cnt_q  <= chg_cnt_d;
		end
	end

endmodule

// ===== design/current_direction_qualifier_unit.sv =====
// channel | signals                                    | beat
// sample  | sample_valid, sample_ready, total_current  | one current sample
// result  | result_valid, result_ready, direction, ... | direction, direction_changed
// config  | psel, penable, pwrite, paddr, pwdata, ...  | one register write or read
//
// One sample per cycle sustained while result_ready is high. A sample passes through
// the input register, then the result register, before its result appears.
// Direction state and counters update as a sample moves into the result register.
// sample_ready depends combinationally on result_ready; a stall holds both registers.
// Reset clears state, counters and valids and loads register defaults.
module current_direction_qualifier_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  logic signed [15:0]          total_current,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [1:0]                  direction,
	output logic                        direction_changed,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cdq_pkg::ADDR_W-1:0]  paddr,
	input  logic [cdq_pkg::DATA_W-1:0]  pwdata,
	output logic [cdq_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import cdq_pkg::*;

	cfg_t               cfg;
	res_t               res;
	logic               valid_s1, valid_s2, adv;
	logic signed [15:0] cur_s1;
	res_t               res_s2;

	assign pready       = 1'b1;
	assign adv          = valid_s1 && (!valid_s2 || result_ready);
	assign sample_ready = !valid_s1 || adv;

	cdq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	cdq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.cur    (cur_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_valid && sample_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			cur_s1 <= total_current;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign result_valid      = valid_s2;
	assign direction         = res_s2.direction;
	assign direction_changed = res_s2.changed;

endmodule

// ===== design/cdq_checker.sv =====
module cdq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [1:0] direction,
	input logic       direction_changed,
	input logic       pready
);
	import cdq_pkg::*;

	logic beat;
	assign beat = result_valid && result_ready;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(direction)
			&& $stable(direction_changed))
		else $error("result beat changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> direction != 2'd3)
		else $error("unused direction code");

	a_same: assert property (@(posedge clk) disable iff (!arst_n)
		beat ##1 (beat && !direction_changed) |-> direction == $past(direction))
		else $error("direction moved without change flag");

	a_diff: assert property (@(posedge clk) disable iff (!arst_n)
		beat ##1 (beat && direction_changed) |-> direction != $past(direction))
		else $error("change flag without new direction");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind current_direction_qualifier_unit cdq_checker u_cdq_checker (.*);
